// ----- hdl/variable_coefficient_error_diffusion_assert.svh -----
// ----------------------------------------------------------------------------
// variable_coefficient_error_diffusion_assert.svh
// Assertion macros used by the halftoner top level.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_COEFFICIENT_ERROR_DIFFUSION_ASSERT_SVH
`define VARIABLE_COEFFICIENT_ERROR_DIFFUSION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define VCED_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define VCED_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/vced_pkg.sv -----
// ----------------------------------------------------------------------------
// vced_pkg
// Shared types, constants and coefficient tables of the halftoner.
// ----------------------------------------------------------------------------
`default_nettype none

package vced_pkg;

  localparam int WGT_W = 21;

  localparam logic       CFG_WIDTH  = 1'b0;
  localparam logic       CFG_HEIGHT = 1'b1;

  localparam logic [11:0] WID_RST    = 12'd640;
  localparam logic [12:0] HGT_RST    = 13'd480;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  localparam logic [7:0]  THR_FLAT = 8'd127;
  localparam logic [7:0]  THR_BASE = 8'd128;
  localparam logic [8:0]  OUT_HI   = 9'd255;
  // x/100 == (x*5243)>>19 for x below 43690
  localparam logic [12:0] RECIP    = 13'd5243;
  localparam int          RECIP_SH = 19;

  typedef struct packed {
    logic [7:0]       gray;
    logic [6:0]       noise;
    logic [6:0]       scale;
    logic [WGT_W-1:0] wf;
    logic [WGT_W-1:0] wdb;
    logic [WGT_W-1:0] sum;
    logic             odd;
    logic             c_nz;
    logic             row_last;
    logic             last_row;
    logic             first_row;
  } item_t;

  localparam logic [WGT_W-1:0] WEIGHT_ROM [128][3] = '{
    '{13,0,5},'{1300249,0,499250},'{214114,287,99357},'{351854,0,199965},
    '{801100,0,490999},'{606569,37983,355446},'{593140,75967,330891},
    '{579711,113951,306337},'{283141,75967,140891},'{552853,189918,257228},
    '{704075,297466,303694},'{76188,33644,33025},'{527209,243114,229676},
    '{521101,250719,228178},'{514994,258325,226679},'{508886,265931,225181},
    '{502779,273537,223682},'{496671,281143,222184},'{490564,288749,220686},
    '{484456,296355,219187},'{478349,303961,217689},'{472242,311567,216190},
    '{46613,31917,21469},'{467003,317873,215123},'{467872,316573,215554},
    '{22321,15013,10285},'{469610,313973,216416},'{470479,312673,216847},
    '{52372,34597,24142},'{472217,310073,217709},'{473086,308773,218140},
    '{157985,102491,72857},'{47482,30617,21900},'{472921,298013,229065},
    '{471018,289853,239128},'{469115,281693,249191},'{467211,273533,259254},
    '{465308,265374,269317},'{463405,257214,279380},'{153834,83018,96481},
    '{45959,24089,29950},'{452279,286018,261701},'{444960,331142,223897},
    '{437641,376266,186092},'{43024,42131,14826},'{427011,421930,151058},
    '{211850,211235,76914},'{210195,211505,78299},'{208540,211775,79684},
    '{413769,424091,162139},'{410459,424631,164909},'{407148,425171,167679},
    '{403838,425711,170449},'{400528,426251,173219},'{397217,426792,175990},
    '{393907,427332,178760},'{195298,213936,90765},'{193643,214206,92150},
    '{383976,428953,187070},'{380665,429493,189841},'{377355,430033,192611},
    '{374044,430573,195381},'{370734,431113,198151},'{367424,431654,200921},
    '{36411,43219,20369},'{366696,445475,187828},'{369279,458755,171964},
    '{185931,236018,78050},'{374445,485317,140236},'{188514,249299,62186},
    '{379611,511879,108509},'{382194,525159,92645},'{38477,53843,7678},
    '{388829,533848,77321},'{392881,529256,77861},'{396933,524664,78401},
    '{400986,520072,78941},'{40503,51547,7948},'{399240,493681,107078},
    '{393441,471883,134674},'{38764,45008,16227},'{381845,428284,189869},
    '{376047,406484,217468},'{370249,384683,245066},'{364451,362883,272664},
    '{35865,34108,30026},'{356905,343874,299219},'{355157,346665,298176},
    '{353409,349456,297133},'{351661,352247,296090},'{349913,355038,295047},
    '{348165,357829,294004},'{346417,360620,292961},'{344669,363411,291918},
    '{342921,366202,290875},'{34117,36899,28983},'{342623,367794,289581},
    '{172037,183297,144665},'{345524,365395,289079},'{346975,364195,288828},
    '{348425,362996,288577},'{174938,180898,144163},'{35132,36059,28807},
    '{346970,363719,289309},'{342614,366841,290543},'{338258,369963,291777},
    '{333902,373085,293011},'{16477,18810,14712},'{330357,376874,292767},
    '{331169,377542,291288},'{331980,378209,289810},'{332791,378876,288331},
    '{33360,37954,28685},'{334876,378285,286838},'{168074,188513,143412},
    '{337421,375767,286810},'{338694,374509,286796},'{169983,186625,143391},
    '{341239,371991,286768},'{342512,370733,286754},'{171892,184737,143370},
    '{345057,368215,286726},'{346330,366957,286712},'{173801,182849,143349},
    '{348875,364439,286684},'{175074,181590,143335},'{175710,180961,143328},
    '{35269,36066,28664}
  };

  localparam logic [6:0] SCALE_ROM [128] = '{
    0,0,1,2,3,3,4,5,6,6, 7,8,9,9,10,11,12,12,13,14,
    15,15,16,17,18,18,19,20,21,21, 22,23,24,24,25,26,27,27,28,29,
    30,31,32,33,34,34,35,36,37,38, 38,39,40,41,42,42,43,44,45,46,
    46,47,48,49,50,53,56,59,62,65, 68,71,75,78,81,84,87,90,93,96,
    100,100,100,100,100,100,91,83,75,66, 58,50,41,33,25,17,21,26,31,35,
    40,45,50,54,58,62,66,70,71,73, 75,77,79,80,81,83,84,86,87,88,
    90,91,93,94,95,97,98,100
  };

endpackage

`default_nettype wire

// ----- hdl/vced_front.sv -----
// ----------------------------------------------------------------------------
// vced_front
// Config registers, scan counters and table lookup; feeds the pixel queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vced_front import vced_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [12:0]                   cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_gray,
  input  wire logic [6:0]                    in_noise,
  input  wire logic                          q_full,
  output logic                               q_push,
  output item_t                              q_item,
  output logic [$clog2(MAX_WIDTH)-1:0]       q_x
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = (XW + 1 > 12) ? XW + 1 : 12;

  logic [11:0]   wid_r;
  logic [12:0]   hgt_r;
  logic [XW-1:0] col_r;
  logic [11:0]   row_r;

  logic          fv_r;
  logic [7:0]    f_gray_r;
  logic [6:0]    f_noise_r;
  logic [XW-1:0] f_x_r;
  logic          f_odd_r, f_cnz_r, f_rlast_r, f_lrow_r, f_frow_r;

  logic [CW-1:0] wid_ext, weff, col_ext;
  logic [12:0]   heff;
  logic          row_last, last_row, odd, accept;
  logic [XW-1:0] x;
  logic [6:0]    level;

  always_comb begin
    wid_ext = CW'(wid_r);
    if (wid_r == '0) begin
      weff = CW'(1);
    end else if (wid_ext > CW'(MAX_WIDTH)) begin
      weff = CW'(MAX_WIDTH);
    end else begin
      weff = wid_ext;
    end
    if (hgt_r == '0) begin
      heff = 13'd1;
    end else if (hgt_r > MAX_HEIGHT) begin
      heff = MAX_HEIGHT;
    end else begin
      heff = hgt_r;
    end
    col_ext  = CW'(col_r);
    row_last = (col_ext + CW'(1)) >= weff;
    last_row = (13'(row_r) + 13'd1) >= heff;
    odd      = row_r[0];
    x        = odd ? XW'(weff - CW'(1) - col_ext) : col_r;
  end

  assign in_ready = !fv_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = fv_r && !q_full;

  // fold to 0..127: 255-g is ~g for g above 127
  assign level = f_gray_r[7] ? ~f_gray_r[6:0] : f_gray_r[6:0];

  always_comb begin
    q_item           = '0;
    q_item.gray      = f_gray_r;
    q_item.noise     = f_noise_r;
    q_item.scale     = SCALE_ROM[level];
    q_item.wf        = WEIGHT_ROM[level][0];
    q_item.wdb       = WEIGHT_ROM[level][1];
    q_item.sum       = WEIGHT_ROM[level][0] + WEIGHT_ROM[level][1] + WEIGHT_ROM[level][2];
    q_item.odd       = f_odd_r;
    q_item.c_nz      = f_cnz_r;
    q_item.row_last  = f_rlast_r;
    q_item.last_row  = f_lrow_r;
    q_item.first_row = f_frow_r;
  end

  assign q_x = f_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_r <= WID_RST;
      hgt_r <= HGT_RST;
      col_r <= '0;
      row_r <= '0;
      fv_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  wid_r <= cfg_wdata[11:0];
          CFG_HEIGHT: hgt_r <= cfg_wdata;
          default: ;
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        if (row_last) begin
          col_r <= '0;
          row_r <= last_row ? 12'd0 : row_r + 12'd1;
        end else begin
          col_r <= col_r + XW'(1);
        end
      end
      if (accept) begin
        fv_r <= 1'b1;
      end else if (q_push) begin
        fv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_gray_r  <= in_gray;
      f_noise_r <= in_noise;
      f_x_r     <= x;
      f_odd_r   <= odd;
      f_cnz_r   <= col_r != '0;
      f_rlast_r <= row_last;
      f_lrow_r  <= last_row;
      f_frow_r  <= row_r == '0;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/vced_fifo.sv -----
// ----------------------------------------------------------------------------
// vced_fifo
// Two-entry queue between the front and the error-diffusion engine.
// ----------------------------------------------------------------------------
`default_nettype none

module vced_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              head_valid,
  output logic [W-1:0]      head_data
);

  logic [W-1:0] ent_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head_data  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

endmodule

`default_nettype wire

// ----- hdl/vced_div.sv -----
// ----------------------------------------------------------------------------
// vced_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vced_div #(
  parameter int QW = 12,
  parameter int DW = 21
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [QW+DW-1:0] num,
  input  wire logic [DW-1:0]   den,
  output logic                 busy,
  output logic [QW-1:0]        quot
);

  localparam int CNTW = (QW > 1) ? $clog2(QW) : 1;

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW-1:0]   rem_r;
  logic [QW-1:0]   q_r;
  logic [DW:0]     trial, diff;
  logic            ge;

  // caller guarantees num < den * 2^QW, so the top slice starts below den
  assign trial = {rem_r, q_r[QW-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};
  assign busy  = busy_r;
  assign quot  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(QW - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      cnt_r <= cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[QW+DW-1:QW];
      q_r   <= num[QW-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/vced_back.sv -----
// ----------------------------------------------------------------------------
// vced_back
// Error-diffusion engine: threshold, error split, line buffer, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module vced_back import vced_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int ERROR_BITS = 11
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          restart,
  input  wire logic                          head_valid,
  input  wire item_t                         head,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  head_x,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_halftone_bit,
  output logic                               out_row_end
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int EB = ERROR_BITS;
  localparam int AW = EB + 2;       // accumulated pixel / error
  localparam int MW = EB + 1;       // error magnitude, quotient
  localparam int PW = MW + WGT_W;   // magnitude * weight
  localparam int SW = AW + 1;       // sums before saturation
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-EB+1){1'b0}}, {(EB-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [2:0] {
    S_IDLE, S_ACC, S_MUL, S_LOAD, S_DIV, S_FIN, S_FLUSH
  } state_t;

  function automatic logic signed [EB-1:0] sat_err(input logic signed [SW-1:0] v);
    logic signed [EB-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[EB-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[EB-1:0];
    end else begin
      r = v[EB-1:0];
    end
    return r;
  endfunction

  logic signed [EB-1:0] lbuf [MAX_WIDTH];
  logic signed [EB-1:0] rd_r;

  state_t               state_r;
  logic                 out_valid_r, out_bit_r, out_end_r;
  logic signed [EB-1:0] fc_r, pend_r;
  logic [XW-1:0]        pend_x_r;
  logic [13:0]          nprod_r;
  logic                 bit_r, neg_r;
  logic signed [AW-1:0] err_r;
  logic [MW-1:0]        mag_r;
  logic [PW-1:0]        pf_r, pd_r;

  logic [XW-1:0]        xb;
  logic [26:0]          thr_prod;
  logic signed [AW-1:0] thr, acc, err;
  logic                 bit_c;
  logic [MW-1:0]        qf, qd;
  logic                 busy_f, busy_d, div_go, fin_go;
  logic signed [AW-1:0] fwd, db;
  logic signed [SW-1:0] down, add;
  logic                 mem_we;
  logic [XW-1:0]        mem_wa;
  logic signed [EB-1:0] mem_wd;

  assign xb = head.odd ? head_x + XW'(1) : head_x - XW'(1);

  always_comb begin
    thr_prod = 27'(nprod_r) * 27'(RECIP);
    thr = (head.scale == '0) ? AW'(THR_FLAT)
                             : AW'(THR_BASE) + AW'(thr_prod >> RECIP_SH);
    acc = AW'({1'b0, head.gray}) + AW'(fc_r) + (head.first_row ? AW'(0) : AW'(rd_r));
    bit_c = acc > thr;
    err = bit_c ? acc - AW'(OUT_HI) : acc;
  end

  assign div_go = state_r == S_LOAD;

  vced_div #(.QW(MW), .DW(WGT_W)) u_div_fwd (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(pf_r), .den(head.sum),
    .busy(busy_f), .quot(qf)
  );

  vced_div #(.QW(MW), .DW(WGT_W)) u_div_db (
    .clk(clk), .rst_n(rst_n), .start(div_go), .num(pd_r), .den(head.sum),
    .busy(busy_d), .quot(qd)
  );

  // truncating division: quotient of magnitudes takes the error's sign
  always_comb begin
    fwd  = neg_r ? -AW'(qf) : AW'(qf);
    db   = neg_r ? -AW'(qd) : AW'(qd);
    // straight-down share plus the remainder
    down = SW'(err_r) - SW'(fwd) - SW'(db);
    add  = SW'(pend_r) + SW'(db);
  end

  assign fin_go = !out_valid_r || out_ready;
  assign pop    = (state_r == S_FIN) && fin_go;

  // down-back target was the previous pixel; its entry is held in pend_r
  // until this add lands, then written once
  always_comb begin
    mem_we = 1'b0;
    mem_wa = xb;
    mem_wd = sat_err(add);
    if (state_r == S_FLUSH) begin
      mem_we = 1'b1;
      mem_wa = pend_x_r;
      mem_wd = pend_r;
    end else if (pop && !head.last_row && head.c_nz) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) lbuf[mem_wa] <= mem_wd;
    rd_r <= lbuf[head_x];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fc_r        <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (restart) fc_r <= '0;
      case (state_r)
        S_IDLE: begin
          if (head_valid) state_r <= S_ACC;
        end
        S_ACC:  state_r <= S_MUL;
        S_MUL:  state_r <= S_LOAD;
        S_LOAD: state_r <= S_DIV;
        S_DIV: begin
          if (!busy_f && !busy_d) state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid_r <= 1'b1;
            fc_r        <= head.row_last ? '0 : sat_err(SW'(fwd));
            state_r     <= (head.row_last && !head.last_row) ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    nprod_r <= 14'(head.noise) * 14'(head.scale);
    if (state_r == S_ACC) begin
      bit_r <= bit_c;
      err_r <= err;
      neg_r <= err[AW-1];
      mag_r <= MW'(err[AW-1] ? -err : err);
    end
    if (state_r == S_MUL) begin
      pf_r <= PW'(mag_r) * PW'(head.wf);
      pd_r <= PW'(mag_r) * PW'(head.wdb);
    end
    if (pop) begin
      out_bit_r <= bit_r;
      out_end_r <= head.row_last;
      if (!head.last_row) begin
        pend_r   <= sat_err(down);
        pend_x_r <= head_x;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_halftone_bit = out_bit_r;
  assign out_row_end      = out_end_r;

endmodule

`default_nettype wire

// ----- hdl/variable_coefficient_error_diffusion.sv -----
// ----------------------------------------------------------------------------
// variable_coefficient_error_diffusion
// Serpentine halftoner with noise-modulated threshold and level-dependent
// diffusion weights.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per pixel (gray, noise) in serpentine scan order.
//   out_* : one beat per pixel: halftone bit and a row-end flag.
//   cfg_* : write image width (index 0) or height (index 1) while idle; any
//           write restarts the image at its top-left pixel.
// Timing: the front registers a pixel and queues it (two-entry queue). The
//   engine then steps each pixel through S_IDLE, S_ACC, S_MUL, S_LOAD, S_DIV
//   and S_FIN, plus S_FLUSH for the line-buffer flush on the last pixel of
//   a row that is not the last row. The two error shares are found by
//   restoring dividers, one bit per cycle; that loop sets the pixel period.
//   out_valid is set when S_FIN retires the pixel to the output register.
// Reset: counters, forward error and handshakes clear synchronously. The line
//   buffer is not swept: the first row reads zero and every later row reads
//   only entries written by the row above.
// Stall: a result waits in the output register; the engine holds the next
//   pixel until it is taken, and the queue then fills and drops in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_coefficient_error_diffusion import vced_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int ERROR_BITS = 11
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_gray,
  input  wire logic [6:0]  in_noise,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_halftone_bit,
  output logic             out_row_end
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int QW = $bits(item_t) + XW;

  logic          q_push, q_full, q_pop, q_head_valid;
  item_t         push_item, head_item;
  logic [XW-1:0] push_x, head_x;
  logic [QW-1:0] head_data;

  vced_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_gray(in_gray), .in_noise(in_noise),
    .q_full(q_full), .q_push(q_push), .q_item(push_item), .q_x(push_x)
  );

  vced_fifo #(.W(QW)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_data({push_x, push_item}), .full(q_full),
    .pop(q_pop), .head_valid(q_head_valid), .head_data(head_data)
  );

  assign head_x    = head_data[QW-1:$bits(item_t)];
  assign head_item = head_data[$bits(item_t)-1:0];

  vced_back #(.MAX_WIDTH(MAX_WIDTH), .ERROR_BITS(ERROR_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .restart(cfg_we),
    .head_valid(q_head_valid), .head(head_item), .head_x(head_x), .pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_halftone_bit(out_halftone_bit), .out_row_end(out_row_end)
  );

`include "variable_coefficient_error_diffusion_assert.svh"

  `VCED_AST_IMP(a_pop_head, q_pop, q_head_valid, "engine retired a beat from an empty queue")
  `VCED_AST_IMP(a_push_room, q_push, !q_full, "front pushed into a full queue")
  `VCED_AST_NXT(a_pop_result, q_pop, out_valid, "retired beat left no result")

endmodule

`default_nettype wire

// ----- tb/tb_variable_coefficient_error_diffusion.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_variable_coefficient_error_diffusion
// Drives pixels through the serpentine halftoner with random handshake gaps
// and checks every halftone bit and row-end flag against an in-bench model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_variable_coefficient_error_diffusion;
  import vced_pkg::*;

  localparam int MAXW = 2048;
  localparam int EBITS = 11;
  localparam int MAXH = 4096;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic bit_o;
    logic row_end;
  } pix_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_WIDTH;
  logic [12:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_gray = '0;
  logic [6:0]  in_noise = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_halftone_bit;
  logic        out_row_end;

  variable_coefficient_error_diffusion #(.MAX_WIDTH(MAXW), .ERROR_BITS(EBITS)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
    .in_gray(in_gray), .in_noise(in_noise), .out_valid(out_valid),
    .out_ready(out_ready), .out_halftone_bit(out_halftone_bit),
    .out_row_end(out_row_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int        line_err [MAXW];
  int        fwd_err;
  int        col_pos;
  int        row_pos;
  int        img_w;
  int        img_h;
  pix_res_t  expected_pix [$];

  int        send_idle_pct;
  int        recv_stall_pct;
  int        mismatches;
  int        beats_out;
  int        pixels_in;
  longint    cycles;

  function automatic int clamp_err(longint v);
    longint lim;
    lim = longint'(1) << (EBITS - 1);
    if (v > lim - 1) return int'(lim - 1);
    if (v < -lim) return int'(-lim);
    return int'(v);
  endfunction

  task automatic predict_pixel(input logic [7:0] g, input logic [6:0] n);
    int w, h, c, x, xb, lvl, scl, thr, acc, err;
    bit odd, top, bottom, last_col, hb;
    longint sm, fw, db, dn;
    pix_res_t r;
    w = (img_w == 0) ? 1 : (img_w > MAXW ? MAXW : img_w);
    h = (img_h == 0) ? 1 : (img_h > MAXH ? MAXH : img_h);
    c = col_pos;
    odd = row_pos[0];
    top = (row_pos == 0);
    bottom = (row_pos + 1 >= h);
    last_col = (c + 1 >= w);
    if (c >= w) c = w - 1;
    x = odd ? (w - 1 - c) : c;
    xb = odd ? x + 1 : x - 1;
    lvl = (g > 127) ? 255 - int'(g) : int'(g);
    scl = int'(SCALE_ROM[lvl]);
    thr = (scl == 0) ? 127 : 128 + (int'(n) * scl) / 100;
    acc = int'(g) + fwd_err + (top ? 0 : line_err[x]);
    hb = (acc > thr);
    err = hb ? acc - 255 : acc;
    sm = longint'(WEIGHT_ROM[lvl][0]) + longint'(WEIGHT_ROM[lvl][1])
       + longint'(WEIGHT_ROM[lvl][2]);
    fw = longint'(err) * longint'(WEIGHT_ROM[lvl][0]) / sm;
    db = longint'(err) * longint'(WEIGHT_ROM[lvl][1]) / sm;
    dn = longint'(err) * longint'(WEIGHT_ROM[lvl][2]) / sm;
    fwd_err = last_col ? 0 : clamp_err(fw);
    if (!bottom) begin
      line_err[x] = clamp_err(dn + (longint'(err) - fw - db - dn));
      if (c > 0 && xb >= 0 && xb < MAXW)
        line_err[xb] = clamp_err(longint'(line_err[xb]) + db);
    end
    r.bit_o = hb;
    r.row_end = last_col;
    expected_pix.push_back(r);
    if (last_col) begin
      col_pos = 0;
      row_pos = bottom ? 0 : row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // valid stays up after a beat until the next pixel or an idle cycle
  task automatic send_pixel(input logic [7:0] g, input logic [6:0] n);
    while (($urandom % 100) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_gray <= g;
    in_noise <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(g, n);
    pixels_in++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pix.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input int val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH) img_w = val & 12'hFFF;
    else img_h = val & 13'h1FFF;
    col_pos = 0;
    row_pos = 0;
    fwd_err = 0;
  endtask

  task automatic set_image(input int w, input int h);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // result checker
  always @(posedge clk) begin
    pix_res_t e;
    cycles++;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (expected_pix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat bit=%0d row_end=%0d",
                                       out_halftone_bit, out_row_end);
      end else begin
        e = expected_pix.pop_front();
        if (e.bit_o !== out_halftone_bit || e.row_end !== out_row_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: expected bit=%0d row_end=%0d, got bit=%0d row_end=%0d",
                     beats_out, e.bit_o, e.row_end, out_halftone_bit, out_row_end);
        end
      end
    end
    if (rst_n) out_ready <= (($urandom % 100) >= recv_stall_pct);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    set_image(4, 3);
    send_pixel(8'd0, 7'd0);
    send_pixel(8'd255, 7'd127);
    send_pixel(8'd127, 7'd127);
    send_pixel(8'd128, 7'd0);
    for (int i = 0; i < 8; i++) send_pixel(8'(i * 37 + 1), 7'(i * 19));
    // degenerate sizes: width and height 0 act as 1, oversized clamps
    set_image(0, 0);
    send_pixel(8'd200, 7'd85);
    send_pixel(8'd64, 7'd42);
    set_image(1, 2);
    send_pixel(8'd255, 7'd127);
    send_pixel(8'd1, 7'd1);
    write_reg(CFG_WIDTH, 4095);
    write_reg(CFG_HEIGHT, 8191);
    send_pixel(8'd100, 7'd64);
    send_pixel(8'd155, 7'd33);
  endtask

  task automatic test_random(input int count, input int w, input int h);
    set_image(w, h);
    for (int i = 0; i < count; i++)
      send_pixel(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endtask

  task automatic test_wide_row();
    set_image(2048, 2);
    for (int i = 0; i < 60; i++)
      send_pixel(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endtask

  task automatic test_full_image_wrap();
    set_image(3, 4096);
    for (int i = 0; i < 30; i++) send_pixel(8'($urandom_range(0, 255)), 7'($urandom));
    set_image(5, 3);
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom_range(0, 255)), 7'($urandom));
  endtask

  initial begin
    for (int k = 0; k < MAXW; k++) line_err[k] = 0;
    fwd_err = 0; col_pos = 0; row_pos = 0;
    img_w = 640; img_h = 480;
    mismatches = 0; beats_out = 0; pixels_in = 0; cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(250, 7, 6);
    send_idle_pct = 86;
    test_random(200, 8, 5);
    // sender holds off until everything is back
    wait_drained();
    send_idle_pct = 0; recv_stall_pct = 86;
    test_random(200, 13, 4);
    send_idle_pct = 13; recv_stall_pct = 13;
    test_random(200, 1, 9);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_wide_row();
    test_full_image_wrap();
    send_idle_pct = 13; recv_stall_pct = 13;
    test_random(100, 640, 480);

    wait_drained();
    $display("Covered %0d pixels over several image sizes incl. clamped extremes,",
             pixels_in);
    $display("with sender gaps and receiver stalls; %0d result beats checked.", beats_out);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
